FILE: rtl/xeu_pkg.sv
// shared types, constants and entity tables for the xml entity unescaper
package xeu_pkg;

	// characters that take part in matching
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LG    = 8'h67;
	localparam logic [7:0] CH_LL    = 8'h6C;
	localparam logic [7:0] CH_LM    = 8'h6D;
	localparam logic [7:0] CH_LO    = 8'h6F;
	localparam logic [7:0] CH_LP    = 8'h70;
	localparam logic [7:0] CH_LQ    = 8'h71;
	localparam logic [7:0] CH_LS    = 8'h73;
	localparam logic [7:0] CH_LT_T  = 8'h74;
	localparam logic [7:0] CH_LU    = 8'h75;

	// pending prefix after an ampersand, named by its text
	typedef enum logic [3:0] {
		M_IDLE     = 4'd0,
		M_E        = 4'd1,
		M_E_A      = 4'd2,
		M_E_AM     = 4'd3,
		M_E_AMP    = 4'd4,
		M_E_AP     = 4'd5,
		M_E_APO    = 4'd6,
		M_E_APOS   = 4'd7,
		M_E_L      = 4'd8,
		M_E_LT     = 4'd9,
		M_E_G      = 4'd10,
		M_E_GT     = 4'd11,
		M_E_Q      = 4'd12,
		M_E_QU     = 4'd13,
		M_E_QUO    = 4'd14,
		M_E_QUOT   = 4'd15
	} match_t;

	// one burst of output work: flushed prefix, optional byte, final flush
	typedef struct packed {
		match_t      pre;
		logic        has_char;
		logic [7:0]  ch;
		match_t      post;
		logic        last;
	} cmd_t;

	// number of characters held by a prefix
	function automatic logic [2:0] prefix_len(input match_t s);
		logic [2:0] n;
		unique case (s)
			M_IDLE:                                   n = 3'd0;
			M_E:                                      n = 3'd1;
			M_E_A, M_E_L, M_E_G, M_E_Q:               n = 3'd2;
			M_E_AM, M_E_AP, M_E_LT, M_E_GT, M_E_QU:   n = 3'd3;
			M_E_AMP, M_E_APO, M_E_QUO:                n = 3'd4;
			M_E_APOS, M_E_QUOT:                       n = 3'd5;
			default:                                  n = 3'd0;
		endcase
		return n;
	endfunction

	// character at a position of a prefix
	function automatic logic [7:0] prefix_char(input match_t s, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (pos)
			3'd0: c = CH_AMP;
			3'd1: begin
				if (s == M_E_A || s == M_E_AM || s == M_E_AMP || s == M_E_AP ||
				    s == M_E_APO || s == M_E_APOS)
					c = CH_LA;
				else if (s == M_E_L || s == M_E_LT)
					c = CH_LL;
				else if (s == M_E_G || s == M_E_GT)
					c = CH_LG;
				else
					c = CH_LQ;
			end
			3'd2: begin
				if (s == M_E_AM || s == M_E_AMP)
					c = CH_LM;
				else if (s == M_E_AP || s == M_E_APO || s == M_E_APOS)
					c = CH_LP;
				else if (s == M_E_LT || s == M_E_GT)
					c = CH_LT_T;
				else
					c = CH_LU;
			end
			3'd3: begin
				if (s == M_E_AMP)
					c = CH_LP;
				else
					c = CH_LO;
			end
			3'd4: begin
				if (s == M_E_APOS)
					c = CH_LS;
				else
					c = CH_LT_T;
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// character produced when a semicolon completes the prefix, zero if none
	function automatic logic [7:0] done_char(input match_t s);
		logic [7:0] c;
		unique case (s)
			M_E_AMP:  c = CH_AMP;
			M_E_APOS: c = CH_APOS;
			M_E_LT:   c = CH_LT;
			M_E_GT:   c = CH_GT;
			M_E_QUOT: c = CH_QUOT;
			default:  c = 8'h00;
		endcase
		return c;
	endfunction

	// prefix that grows s by one character, idle if none does
	function automatic match_t extend(input match_t s, input logic [7:0] c);
		match_t t;
		t = M_IDLE;
		unique case (s)
			M_E: begin
				if (c == CH_LA)
					t = M_E_A;
				else if (c == CH_LL)
					t = M_E_L;
				else if (c == CH_LG)
					t = M_E_G;
				else if (c == CH_LQ)
					t = M_E_Q;
			end
			M_E_A: begin
				if (c == CH_LM)
					t = M_E_AM;
				else if (c == CH_LP)
					t = M_E_AP;
			end
			M_E_AM:  if (c == CH_LP)   t = M_E_AMP;
			M_E_AP:  if (c == CH_LO)   t = M_E_APO;
			M_E_APO: if (c == CH_LS)   t = M_E_APOS;
			M_E_L:   if (c == CH_LT_T) t = M_E_LT;
			M_E_G:   if (c == CH_LT_T) t = M_E_GT;
			M_E_Q:   if (c == CH_LU)   t = M_E_QU;
			M_E_QU:  if (c == CH_LO)   t = M_E_QUO;
			M_E_QUO: if (c == CH_LT_T) t = M_E_QUOT;
			default: t = M_IDLE;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/xeu_if.sv
// stream interfaces for escaped input bytes and unescaped output bytes
interface xeu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xeu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/xeu_front.sv
// front end: tracks the pending entity prefix and classifies each input byte
module xeu_front
	import xeu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	xeu_in_if.sink      din,
	input  logic        q_ready,
	output logic        q_push,
	output cmd_t        q_cmd
);

	match_t     state_q;
	match_t     nxt;
	match_t     ext;
	logic       handled;
	logic       accept;
	logic [7:0] dc;

	assign din.ready = q_ready;
	assign accept    = din.valid && q_ready;
	assign ext       = extend(state_q, din.in_byte);
	assign dc        = done_char(state_q);

	// classify the byte against the pending prefix
	always_comb begin
		handled        = 1'b0;
		nxt            = state_q;
		q_cmd.pre      = M_IDLE;
		q_cmd.has_char = 1'b0;
		q_cmd.ch       = din.in_byte;
		q_cmd.post     = M_IDLE;
		q_cmd.last     = din.in_last;
		if (state_q != M_IDLE) begin
			if (din.in_byte == CH_SEMI && dc != 8'h00) begin
				q_cmd.has_char = 1'b1;
				q_cmd.ch       = dc;
				nxt            = M_IDLE;
				handled        = 1'b1;
			end else if (ext != M_IDLE) begin
				nxt     = ext;
				handled = 1'b1;
			end else begin
				q_cmd.pre = state_q;
				nxt       = M_IDLE;
			end
		end
		if (!handled) begin
			if (din.in_byte == CH_AMP)
				nxt = M_E;
			else
				q_cmd.has_char = 1'b1;
		end
		// end of string flushes what is still pending
		if (din.in_last) begin
			q_cmd.post = nxt;
			nxt        = M_IDLE;
		end
	end

	// only bursts with at least one output byte go to the queue
	assign q_push = accept &&
		(q_cmd.pre != M_IDLE || q_cmd.has_char || q_cmd.post != M_IDLE);

	// match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else if (accept) begin
			state_q <= nxt;
		end
	end

endmodule

FILE: rtl/xeu_queue.sv
// two-entry queue of output bursts between front and back
module xeu_queue
	import xeu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic push_ready,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

FILE: rtl/xeu_back.sv
// back end: expands each burst into output bytes, one per cycle while dout is ready
module xeu_back
	import xeu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  cmd_t    head_cmd,
	output logic    pop,
	xeu_out_if.source dout
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [3:0] len_pre;
	logic [3:0] len_post;
	logic [3:0] total;
	logic [3:0] pos;
	logic [3:0] post_pos;
	logic [7:0] cur_byte;
	logic       is_end;
	logic       load;

	assign len_pre  = {1'b0, prefix_len(head_cmd.pre)};
	assign len_post = {1'b0, prefix_len(head_cmd.post)};
	assign total    = len_pre + {3'b000, head_cmd.has_char} + len_post;
	assign pos      = {1'b0, idx_q};
	assign post_pos = pos - len_pre - {3'b000, head_cmd.has_char};
	assign is_end   = (pos == total - 4'd1);

	// pick the byte at the current position of the burst
	always_comb begin
		if (pos < len_pre)
			cur_byte = prefix_char(head_cmd.pre, idx_q);
		else if (head_cmd.has_char && pos == len_pre)
			cur_byte = head_cmd.ch;
		else
			cur_byte = prefix_char(head_cmd.post, post_pos[2:0]);
	end

	assign load = head_valid && (!valid_q || dout.ready);
	assign pop  = load && is_end;

	assign dout.valid    = valid_q;
	assign dout.out_byte = byte_q;
	assign dout.out_last = last_q;

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			last_q <= head_cmd.last && is_end;
		end
	end

	// position within the burst and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (dout.ready)
				valid_q <= 1'b0;
			if (pop)
				idx_q <= 3'd0;
			else if (load)
				idx_q <= idx_q + 3'd1;
		end
	end

endmodule

FILE: rtl/xml_entity_unescape_top.sv
// top level of the xml predefined entity unescaper
//
// din carries escaped text one byte per transfer, with in_last on the final
// byte of a string. dout carries the unescaped text, with out_last on the
// final byte of the string. &amp; &lt; &gt; &apos; &quot; become one
// character each; a broken prefix is passed through as it came.
// Each input byte is classified in the cycle it is taken and turned into a
// burst of zero to six output bytes, held in a two-entry queue.
// The first byte of a burst passes through a queue entry and the output
// register on its way to dout. Throughput: one output byte per cycle while
// dout is ready, so plain text runs at one byte per cycle; a burst keeps the
// output until its last byte is out, and din stalls once two bursts are queued.
// Bytes that only extend a pending prefix produce nothing at the time.
// Reset clears the match state, the queue and the output valid flag.
// When dout stalls, the output register holds, the queue fills and din
// ready drops; nothing is lost or repeated.
module xml_entity_unescape_top
	import xeu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	xeu_in_if.sink    din,
	xeu_out_if.source dout
);

	logic q_push;
	logic q_ready;
	cmd_t q_cmd;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	// classification front end
	xeu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_cmd   (q_cmd)
	);

	// burst queue
	xeu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.push_ready (q_ready),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// expansion back end
	xeu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.dout       (dout)
	);

endmodule

FILE: tb/xeu_stream_checker.sv
`timescale 1ns / 1ps
// scoreboard that predicts the unescaped byte stream and checks every output transfer
module xeu_stream_checker
	import xeu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	output int         fail_count,
	output int         bytes_owed
);

	localparam int MAX_HELD = 5;

	typedef enum int {
		ENT_AMP,
		ENT_APOS,
		ENT_LT,
		ENT_GT,
		ENT_QUOT,
		ENT_COUNT
	} entity_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_byte_t;

	text_byte_t owed_q[$];
	logic [7:0] held_txt [MAX_HELD];
	int         held_len;
	text_byte_t want;

	// entity name without its semicolon, right-aligned
	function automatic logic [39:0] entity_name(input int e);
		case (entity_t'(e))
			ENT_AMP:  return "&amp";
			ENT_APOS: return "&apos";
			ENT_LT:   return "&lt";
			ENT_GT:   return "&gt";
			default:  return "&quot";
		endcase
	endfunction

	function automatic int entity_len(input int e);
		case (entity_t'(e))
			ENT_AMP:  return 4;
			ENT_APOS: return 5;
			ENT_LT:   return 3;
			ENT_GT:   return 3;
			default:  return 5;
		endcase
	endfunction

	// character that a completed entity stands for
	function automatic logic [7:0] entity_char(input int e);
		case (entity_t'(e))
			ENT_AMP:  return CH_AMP;
			ENT_APOS: return CH_APOS;
			ENT_LT:   return CH_LT;
			ENT_GT:   return CH_GT;
			default:  return CH_QUOT;
		endcase
	endfunction

	function automatic logic [7:0] name_char(input int e, input int pos);
		logic [39:0] nm;
		nm = entity_name(e);
		return nm[(entity_len(e) - 1 - pos) * 8 +: 8];
	endfunction

	// held text agrees with the start of entity e
	function automatic bit held_agrees(input int e);
		bit ok;
		ok = held_len <= entity_len(e);
		for (int i = 0; i < held_len && ok; i++)
			if (held_txt[i] != name_char(e, i))
				ok = 0;
		return ok;
	endfunction

	task automatic owe(input logic [7:0] b);
		text_byte_t t;
		t.data = b;
		t.last = 1'b0;
		owed_q.push_back(t);
	endtask

	// pass the held ampersand and letters through unchanged
	task automatic flush_held();
		for (int i = 0; i < held_len; i++)
			owe(held_txt[i]);
		held_len = 0;
	endtask

	// expected output for one input transfer
	task automatic predict_unescape(input logic [7:0] c, input logic last);
		int         start;
		bit         taken;
		text_byte_t tail;
		start = owed_q.size();
		taken = 0;
		if (held_len != 0) begin
			// semicolon after a whole entity name
			for (int e = 0; e < ENT_COUNT && !taken; e++) begin
				if (c == CH_SEMI && held_len == entity_len(e) && held_agrees(e)) begin
					owe(entity_char(e));
					held_len = 0;
					taken = 1;
				end
			end
			// letter that still fits some entity name
			for (int e = 0; e < ENT_COUNT && !taken; e++) begin
				if (held_len < entity_len(e) && held_agrees(e) &&
				    name_char(e, held_len) == c) begin
					held_txt[held_len] = c;
					held_len = held_len + 1;
					taken = 1;
				end
			end
			if (!taken)
				flush_held();
		end
		// fresh handling of the byte
		if (!taken) begin
			if (c == CH_AMP) begin
				held_txt[0] = CH_AMP;
				held_len = 1;
			end else begin
				owe(c);
			end
		end
		// end of string flushes and marks the final byte of this step
		if (last) begin
			flush_held();
			if (owed_q.size() > start) begin
				tail = owed_q.pop_back();
				tail.last = 1'b1;
				owed_q.push_back(tail);
			end
		end
	endtask

	// compare outputs first, then predict from the input transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			held_len = 0;
			fail_count = 0;
			bytes_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$error("unexpected output transfer: out_byte %h out_last %b",
					       out_byte, out_last);
					fail_count = fail_count + 1;
				end else begin
					want = owed_q.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, out_byte);
						fail_count = fail_count + 1;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, out_last);
						fail_count = fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				predict_unescape(in_byte, in_last);
			bytes_owed <= owed_q.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench top: drives escaped text into the unescaper and gives the verdict
module testbench;
	import xeu_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       sink_ready;
	int         src_gap_pct;
	int         sink_stall_pct;
	int         sink_wait;
	int         fail_count;
	int         bytes_owed;
	int         sent;
	logic [7:0] text_q[$];

	xeu_in_if  din();
	xeu_out_if dout();

	assign dout.ready = sink_ready;

	xml_entity_unescape_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	xeu_stream_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (din.valid),
		.in_ready   (din.ready),
		.in_byte    (din.in_byte),
		.in_last    (din.in_last),
		.out_valid  (dout.valid),
		.out_ready  (dout.ready),
		.out_byte   (dout.out_byte),
		.out_last   (dout.out_last),
		.fail_count (fail_count),
		.bytes_owed (bytes_owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// idle stretch: mostly short, now and then a long one
	function automatic int idle_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// output side stalls at random
	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
			sink_wait = 0;
		end else if (sink_wait > 0) begin
			sink_ready <= 1'b0;
			sink_wait = sink_wait - 1;
		end else begin
			sink_ready <= 1'b1;
			if ($urandom_range(0, 99) < sink_stall_pct)
				sink_wait = idle_length();
		end
	end

	task automatic set_pace(input int pace);
		case (pace)
			0: begin
				src_gap_pct = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_gap_pct = 20;
				sink_stall_pct = 20;
			end
			default: begin
				src_gap_pct = 50;
				sink_stall_pct = 50;
			end
		endcase
	endtask

	// one input transfer, with an optional idle gap in front
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = ($urandom_range(0, 99) < src_gap_pct) ? idle_length() : 0;
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din.valid   <= 1'b1;
		din.in_byte <= b;
		din.in_last <= last;
		@(posedge clk);
		while (!din.ready)
			@(posedge clk);
		sent = sent + 1;
	endtask

	task automatic send_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last && (i == s.len() - 1));
	endtask

	// hold the input off until every owed byte has come out
	task automatic drain_results();
		int waited;
		waited = 0;
		din.valid <= 1'b0;
		@(posedge clk);
		while (bytes_owed != 0 && waited < 100000) begin
			@(posedge clk);
			waited = waited + 1;
		end
	endtask

	// random string built mostly from entities, whole or broken
	task automatic build_string();
		int    tokens;
		int    k;
		string word;
		text_q.delete();
		tokens = $urandom_range(1, 12);
		for (int t = 0; t < tokens; t++) begin
			case ($urandom_range(0, 4))
				0: word = "&amp;";
				1: word = "&apos;";
				2: word = "&lt;";
				3: word = "&gt;";
				default: word = "&quot;";
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: text_q.push_back(8'($urandom_range(0, 255)));
				3, 4, 5: begin
					for (int i = 0; i < word.len(); i++)
						text_q.push_back(word[i]);
				end
				6, 7: begin
					// proper prefix, then something that may break it
					k = $urandom_range(1, word.len() - 1);
					for (int i = 0; i < k; i++)
						text_q.push_back(word[i]);
					case ($urandom_range(0, 4))
						0: text_q.push_back(8'($urandom_range(0, 255)));
						1: text_q.push_back(CH_AMP);
						2: text_q.push_back(CH_SEMI);
						3: text_q.push_back(word[k] - 8'h20);
						default: ;
					endcase
				end
				8: begin
					text_q.push_back(CH_AMP);
					text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
				end
				default: begin
					repeat ($urandom_range(1, 4))
						text_q.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.in_byte = 8'h00;
		din.in_last = 1'b0;
		sent = 0;
		set_pace(0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entity, then broken prefixes, zero byte, upper case, pending at end
		send_text("&lt;&gt;&amp;", 1'b1);
		set_pace(1);
		send_text("&apos;&quot;", 1'b1);
		send_text("&&q", 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("&AMP;", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("&apo&lt;", 1'b0);
		send_text("&qu", 1'b1);
		send_text("&", 1'b1);
		drain_results();

		// random strings under changing pace
		sent = 0;
		while (sent < 360) begin
			set_pace($urandom_range(0, 2));
			build_string();
			for (int i = 0; i < text_q.size(); i++)
				send_byte(text_q[i], i == text_q.size() - 1);
			if ($urandom_range(0, 9) == 0)
				drain_results();
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (bytes_owed != 0)
			$error("results still owed at end of run: %0d", bytes_owed);
		if (fail_count == 0 && bytes_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
